@@ sv/octn_pkg.sv @@
package octn_pkg;

    // Default widths of the vector components and of the output codes.
    localparam int DEF_COMPONENT_BITS = 16;
    localparam int DEF_CODE_BITS      = 8;

endpackage

@@ sv/octn_if.sv @@
// Request channel carrying one normal vector.
interface octn_in_if #(
    parameter int COMPONENT_BITS = octn_pkg::DEF_COMPONENT_BITS
);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] normal_x;
    logic signed [COMPONENT_BITS-1:0] normal_y;
    logic signed [COMPONENT_BITS-1:0] normal_z;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    output ready);
endinterface

// Result channel carrying one pair of octahedral codes.
interface octn_out_if #(
    parameter int CODE_BITS = octn_pkg::DEF_CODE_BITS
);
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] oct_u;
    logic [CODE_BITS-1:0] oct_v;
    logic                 zero_vector;

    modport source (output valid, output oct_u, output oct_v, output zero_vector,
                    input ready);
    modport sink   (input valid, input oct_u, input oct_v, input zero_vector,
                    output ready);
endinterface

@@ sv/octn_prep.sv @@
// Two-stage front end: L1 norm, fold, and the scaled numerators and the
// divisor handed to the division chain.
module octn_prep #(
    parameter int COMPONENT_BITS = octn_pkg::DEF_COMPONENT_BITS,
    parameter int CODE_BITS      = octn_pkg::DEF_CODE_BITS,
    parameter int NW             = COMPONENT_BITS + 2 + CODE_BITS,
    parameter int DW             = COMPONENT_BITS + 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [COMPONENT_BITS-1:0] i_x,
    input  logic signed [COMPONENT_BITS-1:0] i_y,
    input  logic signed [COMPONENT_BITS-1:0] i_z,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [NW-1:0]                    o_num_u,
    output logic [NW-1:0]                    o_num_v,
    output logic [DW-1:0]                    o_den,
    output logic                             o_zero
);
    localparam int W  = COMPONENT_BITS;
    localparam int SW = W + 1;
    localparam int PW = W + 2;

    // Stage A registers.
    logic                r_a_valid;
    logic signed [W-1:0] r_x, r_y;
    logic [W-1:0]        r_ax, r_ay;
    logic [SW-1:0]       r_s;
    logic                r_zneg;

    // Stage B registers.
    logic          r_b_valid;
    logic [NW-1:0] r_num_u, r_num_v;
    logic [DW-1:0] r_den;
    logic          r_zero;

    logic          a_ready, b_ready;
    logic [W-1:0]  ax, ay, az;
    logic [SW-1:0] s_sum;
    logic [PW-1:0] s_dbl, x_ext, y_ext, p_u, p_v;
    logic          s_zero;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Magnitudes and the L1 norm. The most negative value maps to its
    // correct unsigned magnitude.
    always_comb begin
        ax    = i_x[W-1] ? (W'(0) - W'(i_x)) : W'(i_x);
        ay    = i_y[W-1] ? (W'(0) - W'(i_y)) : W'(i_y);
        az    = i_z[W-1] ? (W'(0) - W'(i_z)) : W'(i_z);
        s_sum = SW'(ax) + SW'(ay) + SW'(az);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
        if (i_valid && a_ready) begin
            r_x    <= i_x;
            r_y    <= i_y;
            r_ax   <= ax;
            r_ay   <= ay;
            r_s    <= s_sum;
            r_zneg <= i_z[W-1];
        end
    end

    // Offset coordinate p = a + s in [0, 2s]. In the lower half the fold
    // gives 2s - |y| for a non-negative x and |y| for a negative one.
    always_comb begin
        s_dbl  = {r_s, 1'b0};
        x_ext  = {{(PW-W){r_x[W-1]}}, r_x};
        y_ext  = {{(PW-W){r_y[W-1]}}, r_y};
        s_zero = (r_s == '0);
        if (!r_zneg) begin
            p_u = x_ext + PW'(r_s);
            p_v = y_ext + PW'(r_s);
        end else begin
            p_u = r_x[W-1] ? PW'(r_ay) : (s_dbl - PW'(r_ay));
            p_v = r_y[W-1] ? PW'(r_ax) : (s_dbl - PW'(r_ax));
        end
    end

    // Numerator p * (2^CODE_BITS - 1); a zero vector divides 0 by 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (r_a_valid && b_ready) begin
            r_num_u <= (NW'(p_u) << CODE_BITS) - NW'(p_u);
            r_num_v <= (NW'(p_v) << CODE_BITS) - NW'(p_v);
            r_den   <= s_zero ? DW'(1) : DW'(s_dbl);
            r_zero  <= s_zero;
        end
    end

    assign o_valid = r_b_valid;
    assign o_num_u = r_num_u;
    assign o_num_v = r_num_v;
    assign o_den   = r_den;
    assign o_zero  = r_zero;
endmodule

@@ sv/octn_cell.sv @@
// One restoring-division cell: settles quotient bit BIT of both codes.
module octn_cell #(
    parameter int NW  = 26,
    parameter int DW  = 18,
    parameter int CW  = octn_pkg::DEF_CODE_BITS,
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [NW-1:0] i_rem_u,
    input  logic [NW-1:0] i_rem_v,
    input  logic [DW-1:0] i_den,
    input  logic [CW-1:0] i_q_u,
    input  logic [CW-1:0] i_q_v,
    input  logic          i_zero,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [NW-1:0] o_rem_u,
    output logic [NW-1:0] o_rem_v,
    output logic [DW-1:0] o_den,
    output logic [CW-1:0] o_q_u,
    output logic [CW-1:0] o_q_v,
    output logic          o_zero
);
    logic          r_valid;
    logic [NW-1:0] r_rem_u, r_rem_v;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_q_u, r_q_v;
    logic          r_zero;

    logic [NW-1:0] n_rem_u, n_rem_v;
    logic [CW-1:0] n_q_u, n_q_v;
    logic [NW-1:0] den_sh;
    logic          ge_u, ge_v;
    logic          up_ready;

    assign up_ready = !r_valid || i_ready;
    assign o_ready  = up_ready;

    // Trial subtraction of the divisor shifted to this bit position.
    always_comb begin
        den_sh  = NW'(i_den) << BIT;
        ge_u    = (i_rem_u >= den_sh);
        ge_v    = (i_rem_v >= den_sh);
        n_rem_u = ge_u ? (i_rem_u - den_sh) : i_rem_u;
        n_rem_v = ge_v ? (i_rem_v - den_sh) : i_rem_v;
        n_q_u   = i_q_u | (CW'(ge_u) << BIT);
        n_q_v   = i_q_v | (CW'(ge_v) << BIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (up_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && up_ready) begin
            r_rem_u <= n_rem_u;
            r_rem_v <= n_rem_v;
            r_den   <= i_den;
            r_q_u   <= n_q_u;
            r_q_v   <= n_q_v;
            r_zero  <= i_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_rem_u = r_rem_u;
    assign o_rem_v = r_rem_v;
    assign o_den   = r_den;
    assign o_q_u   = r_q_u;
    assign o_q_v   = r_q_v;
    assign o_zero  = r_zero;
endmodule

@@ sv/octahedral_normal_encoder_unit.sv @@
// Channel   Dir   Port   Payload
// vector    in    i_in   normal_x, normal_y, normal_z (COMPONENT_BITS, signed)
// codes     out   o_out  oct_u, oct_v (CODE_BITS), zero_vector
//
// One vector is taken per cycle when nothing stalls. Two front-end
// stages form the norm, the fold and the numerators, then a chain of
// CODE_BITS division cells settles one quotient bit of both codes each.
// Every stage moves when it is empty or its successor moves, so bubbles
// close up behind a stalled output. Reset clears only the valid bits
// of the stages.
module octahedral_normal_encoder_unit #(
    parameter int COMPONENT_BITS = octn_pkg::DEF_COMPONENT_BITS,
    parameter int CODE_BITS      = octn_pkg::DEF_CODE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    octn_in_if.sink    i_in,
    octn_out_if.source o_out
);
    localparam int CW = CODE_BITS;
    localparam int DW = COMPONENT_BITS + 2;
    localparam int NW = COMPONENT_BITS + 2 + CODE_BITS;

    logic          valid [0:CW];
    logic          ready [0:CW];
    logic [NW-1:0] rem_u [0:CW];
    logic [NW-1:0] rem_v [0:CW];
    logic [DW-1:0] den   [0:CW];
    logic [CW-1:0] q_u   [0:CW];
    logic [CW-1:0] q_v   [0:CW];
    logic          zero  [0:CW];

    // Norm, fold and numerator stages.
    octn_prep #(
        .COMPONENT_BITS (COMPONENT_BITS),
        .CODE_BITS      (CODE_BITS),
        .NW             (NW),
        .DW             (DW)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_x     (i_in.normal_x),
        .i_y     (i_in.normal_y),
        .i_z     (i_in.normal_z),
        .o_valid (valid[0]),
        .i_ready (ready[0]),
        .o_num_u (rem_u[0]),
        .o_num_v (rem_v[0]),
        .o_den   (den[0]),
        .o_zero  (zero[0])
    );

    assign q_u[0] = '0;
    assign q_v[0] = '0;

    // Division chain, most significant quotient bit first.
    for (genvar k = 0; k < CW; k++) begin : g_cell
        octn_cell #(
            .NW  (NW),
            .DW  (DW),
            .CW  (CW),
            .BIT (CW - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[k]),
            .o_ready (ready[k]),
            .i_rem_u (rem_u[k]),
            .i_rem_v (rem_v[k]),
            .i_den   (den[k]),
            .i_q_u   (q_u[k]),
            .i_q_v   (q_v[k]),
            .i_zero  (zero[k]),
            .o_valid (valid[k+1]),
            .i_ready (ready[k+1]),
            .o_rem_u (rem_u[k+1]),
            .o_rem_v (rem_v[k+1]),
            .o_den   (den[k+1]),
            .o_q_u   (q_u[k+1]),
            .o_q_v   (q_v[k+1]),
            .o_zero  (zero[k+1])
        );
    end

    // The last cell's registers are the output register.
    assign o_out.valid       = valid[CW];
    assign ready[CW]         = o_out.ready;
    assign o_out.oct_u       = q_u[CW];
    assign o_out.oct_v       = q_v[CW];
    assign o_out.zero_vector = zero[CW];

    // A zero vector always comes out with both codes cleared.
    a_zero_codes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_vector) |-> (o_out.oct_u == '0 && o_out.oct_v == '0))
        else $error("zero vector with nonzero codes");

    // When the output drains, the whole chain advances and takes a request.
    a_chain_ready : assert property (@(posedge i_clk)
        o_out.ready |-> i_in.ready)
        else $error("input stalled while output is ready");

    // The final remainder is always below the divisor.
    a_rem_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        valid[CW] |-> (rem_u[CW] < NW'(den[CW]) && rem_v[CW] < NW'(den[CW])))
        else $error("division left an oversized remainder");
endmodule
